[hw/rtl/bhe_pkg.sv]
// Shared constants and types of the byte Huffman encoder.
package bhe_pkg;

    // Command codes on the input channel
    localparam logic [1:0] CMD_COUNT  = 2'd0;
    localparam logic [1:0] CMD_BUILD  = 2'd1;
    localparam logic [1:0] CMD_ENCODE = 2'd2;
    localparam logic [1:0] CMD_FLUSH  = 2'd3;

    // Block limits
    localparam int MAX_BLOCK_BYTES = 131072;
    localparam int CODE_LEN_LIMIT  = 32;

    localparam logic [17:0] HIST_MAX   = 18'h3FFFF;
    localparam logic [18:0] TOTAL_MAX  = 19'h7FFFF;
    localparam logic [7:0]  UNUSED_LEN = 8'd255;
    localparam logic [31:0] HEAP_HOLE  = 32'h7FFF_FFFF;
    localparam int          CNT_SHIFT  = 14;

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Classified command word
    typedef struct packed {
        logic       is_count;
        logic       is_build;
        logic       is_encode;
        logic       is_flush;
        logic [7:0] sym;
    } op_t;

endpackage

[hw/rtl/bhe_front.sv]
// Front end: accepts command words, classifies them and queues them for the back end.
module bhe_front
    import bhe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] sym_byte,
    output logic       q_valid,
    output op_t        q_op,
    input  logic       q_pop
);

    op_t             q_mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   cnt_reg, cnt_next;
    op_t             op_in;
    logic            push;
    logic            pop;

    // Classify the incoming command
    always_comb
    begin
        op_in           = '0;
        op_in.sym       = sym_byte;
        case (cmd)
            CMD_COUNT:  op_in.is_count  = 1'b1;
            CMD_BUILD:  op_in.is_build  = 1'b1;
            CMD_ENCODE: op_in.is_encode = 1'b1;
            CMD_FLUSH:  op_in.is_flush  = 1'b1;
            default:    op_in.is_flush  = 1'b1;
        endcase
    end

    assign cmd_stall = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign push      = cmd_valid && !cmd_stall;
    assign q_valid   = (cnt_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_op      = q_mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the queued word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

[hw/rtl/bhe_back.sv]
// Back end: histogram, table build sequencer, bit packer and output word register.
module bhe_back
    import bhe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  op_t         q_op,
    output logic        q_pop,
    output logic        word_valid,
    input  logic        word_stall,
    output logic [31:0] out_word,
    output logic [2:0]  valid_bytes,
    output logic        kind,
    output logic [18:0] stream_bytes,
    output logic        last
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_CNT_WR  = 5'd1;
    localparam logic [4:0] S_ENC_EX  = 5'd2;
    localparam logic [4:0] S_FLUSH   = 5'd3;
    localparam logic [4:0] S_SCAN_RD = 5'd4;
    localparam logic [4:0] S_SCAN_EX = 5'd5;
    localparam logic [4:0] S_TRY     = 5'd6;
    localparam logic [4:0] S_INIT_RD = 5'd7;
    localparam logic [4:0] S_INIT_WR = 5'd8;
    localparam logic [4:0] S_HPY_RD  = 5'd9;
    localparam logic [4:0] S_HPY_LD  = 5'd10;
    localparam logic [4:0] S_HPY_NX  = 5'd11;
    localparam logic [4:0] S_SF_CHK  = 5'd12;
    localparam logic [4:0] S_SF_CMP  = 5'd13;
    localparam logic [4:0] S_MG_RD0  = 5'd14;
    localparam logic [4:0] S_MG_T    = 5'd15;
    localparam logic [4:0] S_MG_RD1  = 5'd16;
    localparam logic [4:0] S_MG_S    = 5'd17;
    localparam logic [4:0] S_MG_NX   = 5'd18;
    localparam logic [4:0] S_DEP_RD  = 5'd19;
    localparam logic [4:0] S_DEP_RD2 = 5'd20;
    localparam logic [4:0] S_DEP_WR  = 5'd21;
    localparam logic [4:0] S_LEAF_RD = 5'd22;
    localparam logic [4:0] S_LEAF_R2 = 5'd23;
    localparam logic [4:0] S_LEAF_WR = 5'd24;
    localparam logic [4:0] S_FAIL_RD = 5'd25;
    localparam logic [4:0] S_FAIL_WR = 5'd26;
    localparam logic [4:0] S_CODE_RD = 5'd27;
    localparam logic [4:0] S_CODE_EX = 5'd28;
    localparam logic [4:0] S_EMIT_RD = 5'd29;
    localparam logic [4:0] S_EMIT    = 5'd30;
    localparam logic [4:0] S_PL_CLR  = 5'd31;

    // Control state
    logic [4:0]   state_reg, state_next;
    logic [4:0]   ret_reg, ret_next;
    logic [7:0]   sym_reg, sym_next;
    logic [8:0]   n_reg, n_next;
    logic [8:0]   i_reg, i_next;
    logic [8:0]   node_reg, node_next;
    logic [7:0]   root_reg, root_next;
    logic [31:0]  cur_val_reg, cur_val_next;
    logic [8:0]   cur_name_reg, cur_name_next;
    logic [31:0]  first_reg, first_next;
    logic [4:0]   k_reg, k_next;
    logic [4:0]   len_reg, len_next;
    logic [31:0]  code_reg, code_next;
    logic [7:0]   first_sym_reg, first_sym_next;
    logic [31:0]  buf_reg, buf_next;
    logic [5:0]   fill_reg, fill_next;
    logic [18:0]  total_reg, total_next;
    logic [17:0]  enc_cnt_reg, enc_cnt_next;
    logic [255:0] hvalid_reg, hvalid_next;

    // Output word register
    logic         ovalid_reg;
    logic [31:0]  oword_reg;
    logic [2:0]   ovb_reg;
    logic         okind_reg;
    logic [18:0]  osb_reg;
    logic         olast_reg;
    logic         out_free;
    logic         emit;
    logic [31:0]  e_word;
    logic [2:0]   e_vb;
    logic         e_kind;
    logic [18:0]  e_sb;
    logic         e_last;

    // Memories
    logic [17:0]  hist_mem [256];
    logic [7:0]   hs_ra;
    logic [17:0]  hs_rd;
    logic         hvld_rd;
    logic         hs_we;
    logic [17:0]  hs_wd;

    logic [31:0]  lt_mem [64];
    logic [7:0]   lt_ra;
    logic [31:0]  lt_rd;
    logic [1:0]   lt_lane_reg;
    logic         lt_we;
    logic [7:0]   lt_wa;
    logic [7:0]   lt_wd;

    logic [30:0]  ct_mem [256];
    logic [7:0]   ct_ra;
    logic [30:0]  ct_rd;
    logic         ct_we;
    logic [30:0]  ct_wd;

    logic [31:0]  hv_mem [256];
    logic [8:0]   hn_mem [256];
    logic [7:0]   hv_ra0, hv_ra1;
    logic [31:0]  hv_rd0, hv_rd1;
    logic [8:0]   hn_rd0, hn_rd1;
    logic         hv_we;
    logic [7:0]   hv_wa;
    logic [31:0]  hv_wd;
    logic [8:0]   hn_wd;

    logic [8:0]   pl_mem [512];
    logic [8:0]   pl_ra;
    logic [8:0]   pl_rd;
    logic         pl_we;
    logic [8:0]   pl_wa;
    logic [8:0]   pl_wd;

    logic [7:0]   dp_mem [512];
    logic [8:0]   dp_ra;
    logic [7:0]   dp_rd;
    logic         dp_we;
    logic [8:0]   dp_wa;
    logic [7:0]   dp_wd;

    logic [25:0]  us_mem [256];
    logic [7:0]   us_ra;
    logic [25:0]  us_rd;
    logic         us_we;
    logic [7:0]   us_wa;
    logic [25:0]  us_wd;
    logic [7:0]   us_sym;
    logic [17:0]  us_cnt;

    // Datapath helpers
    logic [17:0]  hist_eff;
    logic [7:0]   lt_byte;
    logic [8:0]   c_idx, c1_idx;
    logic         pick1;
    logic [31:0]  pick_val;
    logic [8:0]   pick_name;
    logic [7:0]   pick_idx;
    logic [9:0]   n2m2, n2m3;
    logic [6:0]   enc_sum;
    logic [6:0]   enc_sh;
    logic [63:0]  enc_acc;
    logic [2:0]   flush_vb;
    logic [2:0]   add_amt;
    logic [19:0]  tot_sum;
    logic [18:0]  tot_sat;
    logic [4:0]   code_sh;
    logic [8:0]   leaf_len;

    assign us_sym   = us_rd[25:18];
    assign us_cnt   = us_rd[17:0];
    assign hist_eff = hvld_rd ? hs_rd : 18'd0;
    assign lt_byte  = lt_rd[{~lt_lane_reg, 3'b000} +: 8];

    // Heap child selection
    assign c_idx     = {root_reg, 1'b1};
    assign c1_idx    = c_idx + 9'd1;
    assign pick1     = (c1_idx < n_reg) && (hv_rd0 > hv_rd1);
    assign pick_val  = pick1 ? hv_rd1 : hv_rd0;
    assign pick_name = pick1 ? hn_rd1 : hn_rd0;
    assign pick_idx  = pick1 ? c1_idx[7:0] : c_idx[7:0];
    assign n2m2      = {n_reg, 1'b0} - 10'd2;
    assign n2m3      = {n_reg, 1'b0} - 10'd3;

    // Bit packer
    assign enc_sum  = 7'(fill_reg) + 7'(lt_byte[4:0]);
    assign enc_sh   = 7'd64 - enc_sum;
    assign enc_acc  = {buf_reg, 32'h0} | ({33'h0, ct_rd} << enc_sh);
    assign flush_vb = 3'((7'(fill_reg) + 7'd7) >> 3);
    assign add_amt  = (state_reg == S_FLUSH) ? flush_vb : 3'd4;
    assign tot_sum  = {1'b0, total_reg} + 20'(add_amt);
    assign tot_sat  = (tot_sum > 20'(TOTAL_MAX)) ? TOTAL_MAX : tot_sum[18:0];

    // Canonical code step
    assign code_sh  = 5'(6'd32 - 6'(len_reg));
    assign leaf_len = {1'b0, dp_rd} + 9'd1;

    assign out_free = !ovalid_reg || !word_stall;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    // Read address selection
    always_comb
    begin
        hs_ra  = (state_reg == S_IDLE) ? q_op.sym :
                 (state_reg == S_SCAN_RD) ? i_reg[7:0] : sym_reg;
        ct_ra  = (state_reg == S_IDLE) ? q_op.sym : sym_reg;
        case (state_reg)
            S_IDLE:              lt_ra = q_op.sym;
            S_CODE_RD, S_CODE_EX: lt_ra = i_reg[7:0];
            S_EMIT_RD, S_EMIT:   lt_ra = {i_reg[5:0], 2'b00};
            default:             lt_ra = sym_reg;
        endcase
        case (state_reg)
            S_SF_CHK: hv_ra0 = c_idx[7:0];
            S_HPY_RD: hv_ra0 = i_reg[7:0];
            default:  hv_ra0 = 8'd0;
        endcase
        hv_ra1 = c1_idx[7:0];
        pl_ra  = i_reg;
        dp_ra  = pl_rd;
        us_ra  = i_reg[7:0];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        sym_next       = sym_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        node_next      = node_reg;
        root_next      = root_reg;
        cur_val_next   = cur_val_reg;
        cur_name_next  = cur_name_reg;
        first_next     = first_reg;
        k_next         = k_reg;
        len_next       = len_reg;
        code_next      = code_reg;
        first_sym_next = first_sym_reg;
        buf_next       = buf_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        enc_cnt_next   = enc_cnt_reg;
        hvalid_next    = hvalid_reg;

        emit   = 1'b0;
        e_word = '0;
        e_vb   = '0;
        e_kind = 1'b0;
        e_sb   = '0;
        e_last = 1'b0;

        hs_we = 1'b0;
        hs_wd = hist_eff + 18'd1;
        lt_we = 1'b0;
        lt_wa = i_reg[7:0];
        lt_wd = UNUSED_LEN;
        ct_we = 1'b0;
        ct_wd = 31'(code_reg >> code_sh);
        hv_we = 1'b0;
        hv_wa = root_reg;
        hv_wd = cur_val_reg;
        hn_wd = cur_name_reg;
        pl_we = 1'b0;
        pl_wa = hn_rd0;
        pl_wd = node_reg;
        dp_we = 1'b0;
        dp_wa = i_reg;
        dp_wd = dp_rd + 8'd1;
        us_we = 1'b0;
        us_wa = n_reg[7:0];
        us_wd = {i_reg[7:0], hist_eff};

        case (state_reg)
            // Take the next command word
            S_IDLE:
            begin
                if (q_valid)
                begin
                    sym_next = q_op.sym;
                    if (q_op.is_count)
                    begin
                        state_next = S_CNT_WR;
                    end
                    else if (q_op.is_build)
                    begin
                        i_next     = '0;
                        n_next     = '0;
                        state_next = S_SCAN_RD;
                    end
                    else if (q_op.is_encode)
                    begin
                        if (enc_cnt_reg < 18'(MAX_BLOCK_BYTES))
                        begin
                            enc_cnt_next = enc_cnt_reg + 18'd1;
                            state_next   = S_ENC_EX;
                        end
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end

            // Bump the histogram bin, saturating
            S_CNT_WR:
            begin
                if (hist_eff != HIST_MAX)
                begin
                    hs_we                = 1'b1;
                    hvalid_next[sym_reg] = 1'b1;
                end
                state_next = S_IDLE;
            end

            // Append one code to the bit buffer
            S_ENC_EX:
            begin
                if (lt_byte == 8'd0 || lt_byte > 8'd31)
                begin
                    state_next = S_IDLE;
                end
                else if (enc_sum >= 7'd32)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_word     = enc_acc[63:32];
                        e_vb       = 3'd4;
                        e_kind     = 1'b1;
                        buf_next   = enc_acc[31:0];
                        fill_next  = 6'(enc_sum - 7'd32);
                        total_next = tot_sat;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    buf_next   = enc_acc[63:32];
                    fill_next  = 6'(enc_sum);
                    state_next = S_IDLE;
                end
            end

            // Drain the partial word and clear the block
            S_FLUSH:
            begin
                if (out_free)
                begin
                    emit         = 1'b1;
                    e_word       = (flush_vb != 3'd0) ? buf_reg : 32'h0;
                    e_vb         = flush_vb;
                    e_kind       = 1'b1;
                    e_sb         = tot_sat;
                    e_last       = 1'b1;
                    hvalid_next  = '0;
                    buf_next     = '0;
                    fill_next    = '0;
                    total_next   = '0;
                    enc_cnt_next = '0;
                    state_next   = S_IDLE;
                end
            end

            // Collect used symbols and preset all lengths
            S_SCAN_RD:
            begin
                state_next = S_SCAN_EX;
            end

            S_SCAN_EX:
            begin
                lt_we = 1'b1;
                if (hist_eff != 18'd0)
                begin
                    us_we  = 1'b1;
                    n_next = n_reg + 9'd1;
                    if (n_reg == 9'd0)
                    begin
                        first_sym_next = i_reg[7:0];
                    end
                end
                if (i_reg[7:0] == 8'd255)
                begin
                    state_next = S_TRY;
                end
                else
                begin
                    i_next     = i_reg + 9'd1;
                    state_next = S_SCAN_RD;
                end
            end

            // Handle empty and lone-symbol blocks, else start the first offset
            S_TRY:
            begin
                if (n_reg == 9'd0)
                begin
                    len_next   = 5'd31;
                    i_next     = 9'd255;
                    code_next  = '0;
                    state_next = S_CODE_RD;
                end
                else if (n_reg == 9'd1)
                begin
                    lt_we      = 1'b1;
                    lt_wa      = first_sym_reg;
                    lt_wd      = 8'd1;
                    len_next   = 5'd31;
                    i_next     = 9'd255;
                    code_next  = '0;
                    state_next = S_CODE_RD;
                end
                else
                begin
                    k_next     = '0;
                    i_next     = '0;
                    state_next = S_INIT_RD;
                end
            end

            // Load the heap with shifted counts plus offset
            S_INIT_RD:
            begin
                state_next = S_INIT_WR;
            end

            S_INIT_WR:
            begin
                hv_we = 1'b1;
                hv_wa = i_reg[7:0];
                hv_wd = 32'({us_cnt, 14'b0}) + (32'd1 << k_reg);
                hn_wd = i_reg;
                if (i_reg == n_reg - 9'd1)
                begin
                    i_next     = (n_reg >> 1) - 9'd1;
                    state_next = S_HPY_RD;
                end
                else
                begin
                    i_next     = i_reg + 9'd1;
                    state_next = S_INIT_RD;
                end
            end

            // Heapify from the last parent down to the root
            S_HPY_RD:
            begin
                state_next = S_HPY_LD;
            end

            S_HPY_LD:
            begin
                cur_val_next  = hv_rd0;
                cur_name_next = hn_rd0;
                root_next     = i_reg[7:0];
                ret_next      = S_HPY_NX;
                state_next    = S_SF_CHK;
            end

            S_HPY_NX:
            begin
                if (i_reg == 9'd0)
                begin
                    state_next = S_PL_CLR;
                end
                else
                begin
                    i_next     = i_reg - 9'd1;
                    state_next = S_HPY_RD;
                end
            end

            // Point every node link at the root before merging
            S_PL_CLR:
            begin
                pl_we = 1'b1;
                pl_wa = i_reg;
                pl_wd = n2m2[8:0];
                if (i_reg == n2m3[8:0])
                begin
                    node_next  = n_reg;
                    state_next = S_MG_RD0;
                end
                else
                begin
                    i_next     = i_reg + 9'd1;
                    state_next = S_PL_CLR;
                end
            end

            // Sift the held item down one level per pass
            S_SF_CHK:
            begin
                if (c_idx < n_reg)
                begin
                    state_next = S_SF_CMP;
                end
                else
                begin
                    hv_we      = 1'b1;
                    state_next = ret_reg;
                end
            end

            S_SF_CMP:
            begin
                hv_we = 1'b1;
                if (cur_val_reg > pick_val)
                begin
                    hv_wd      = pick_val;
                    hn_wd      = pick_name;
                    root_next  = pick_idx;
                    state_next = S_SF_CHK;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end

            // Merge the two smallest nodes into a new parent
            S_MG_RD0:
            begin
                state_next = S_MG_T;
            end

            S_MG_T:
            begin
                first_next    = hv_rd0;
                pl_we         = 1'b1;
                cur_val_next  = HEAP_HOLE;
                cur_name_next = hn_rd0;
                root_next     = '0;
                ret_next      = S_MG_RD1;
                state_next    = S_SF_CHK;
            end

            S_MG_RD1:
            begin
                state_next = S_MG_S;
            end

            S_MG_S:
            begin
                pl_we         = 1'b1;
                cur_val_next  = hv_rd0 + first_reg;
                cur_name_next = node_reg;
                root_next     = '0;
                ret_next      = S_MG_NX;
                state_next    = S_SF_CHK;
            end

            S_MG_NX:
            begin
                if ({1'b0, node_reg} == n2m2)
                begin
                    dp_we = 1'b1;
                    dp_wa = n2m2[8:0];
                    dp_wd = 8'd0;
                    if (n_reg >= 9'd3)
                    begin
                        i_next     = n2m3[8:0];
                        state_next = S_DEP_RD;
                    end
                    else
                    begin
                        i_next     = '0;
                        state_next = S_LEAF_RD;
                    end
                end
                else
                begin
                    node_next  = node_reg + 9'd1;
                    state_next = S_MG_RD0;
                end
            end

            // Depth of each inner node from its parent
            S_DEP_RD:
            begin
                state_next = S_DEP_RD2;
            end

            S_DEP_RD2:
            begin
                state_next = S_DEP_WR;
            end

            S_DEP_WR:
            begin
                dp_we = 1'b1;
                if (i_reg == n_reg)
                begin
                    i_next     = '0;
                    state_next = S_LEAF_RD;
                end
                else
                begin
                    i_next     = i_reg - 9'd1;
                    state_next = S_DEP_RD;
                end
            end

            // Leaf lengths; abort the offset if one is too long
            S_LEAF_RD:
            begin
                state_next = S_LEAF_R2;
            end

            S_LEAF_R2:
            begin
                state_next = S_LEAF_WR;
            end

            S_LEAF_WR:
            begin
                if (leaf_len >= 9'(CODE_LEN_LIMIT))
                begin
                    i_next = '0;
                    if (k_reg == 5'd31)
                    begin
                        state_next = S_FAIL_RD;
                    end
                    else
                    begin
                        k_next     = k_reg + 5'd1;
                        state_next = S_INIT_RD;
                    end
                end
                else
                begin
                    lt_we = 1'b1;
                    lt_wa = us_sym;
                    lt_wd = leaf_len[7:0];
                    if (i_reg == n_reg - 9'd1)
                    begin
                        len_next   = 5'd31;
                        i_next     = 9'd255;
                        code_next  = '0;
                        state_next = S_CODE_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 9'd1;
                        state_next = S_LEAF_RD;
                    end
                end
            end

            // No offset fits: flat length for every used symbol
            S_FAIL_RD:
            begin
                state_next = S_FAIL_WR;
            end

            S_FAIL_WR:
            begin
                lt_we = 1'b1;
                lt_wa = us_sym;
                lt_wd = 8'd8;
                if (i_reg == n_reg - 9'd1)
                begin
                    len_next   = 5'd31;
                    i_next     = 9'd255;
                    code_next  = '0;
                    state_next = S_CODE_RD;
                end
                else
                begin
                    i_next     = i_reg + 9'd1;
                    state_next = S_FAIL_RD;
                end
            end

            // Canonical codes, longest length and highest symbol first
            S_CODE_RD:
            begin
                state_next = S_CODE_EX;
            end

            S_CODE_EX:
            begin
                if (lt_byte == {3'b000, len_reg})
                begin
                    ct_we     = 1'b1;
                    code_next = code_reg + (32'd1 << code_sh);
                end
                if (i_reg[7:0] == 8'd0)
                begin
                    if (len_reg == 5'd1)
                    begin
                        i_next     = '0;
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        len_next   = len_reg - 5'd1;
                        i_next     = 9'd255;
                        state_next = S_CODE_RD;
                    end
                end
                else
                begin
                    i_next     = i_reg - 9'd1;
                    state_next = S_CODE_RD;
                end
            end

            // Send the length table, four lengths per word
            S_EMIT_RD:
            begin
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    emit   = 1'b1;
                    e_word = lt_rd;
                    e_vb   = 3'd4;
                    e_last = (i_reg[5:0] == 6'd63);
                    if (i_reg[5:0] == 6'd63)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 9'd1;
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            buf_reg     <= '0;
            fill_reg    <= '0;
            total_reg   <= '0;
            enc_cnt_reg <= '0;
            hvalid_reg  <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            buf_reg     <= buf_next;
            fill_reg    <= fill_next;
            total_reg   <= total_next;
            enc_cnt_reg <= enc_cnt_next;
            hvalid_reg  <= hvalid_next;
            if (emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (!word_stall)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Working registers and output payload
    always_ff @(posedge clk)
    begin
        sym_reg       <= sym_next;
        n_reg         <= n_next;
        i_reg         <= i_next;
        node_reg      <= node_next;
        root_reg      <= root_next;
        cur_val_reg   <= cur_val_next;
        cur_name_reg  <= cur_name_next;
        first_reg     <= first_next;
        k_reg         <= k_next;
        len_reg       <= len_next;
        code_reg      <= code_next;
        first_sym_reg <= first_sym_next;
        if (emit)
        begin
            oword_reg <= e_word;
            ovb_reg   <= e_vb;
            okind_reg <= e_kind;
            osb_reg   <= e_sb;
            olast_reg <= e_last;
        end
    end

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (hs_we)
        begin
            hist_mem[sym_reg] <= hs_wd;
        end
        hs_rd   <= hist_mem[hs_ra];
        hvld_rd <= hvalid_reg[hs_ra];

        if (lt_we)
        begin
            lt_mem[lt_wa[7:2]][{~lt_wa[1:0], 3'b000} +: 8] <= lt_wd;
        end
        lt_rd       <= lt_mem[lt_ra[7:2]];
        lt_lane_reg <= lt_ra[1:0];

        if (ct_we)
        begin
            ct_mem[i_reg[7:0]] <= ct_wd;
        end
        ct_rd <= ct_mem[ct_ra];

        if (hv_we)
        begin
            hv_mem[hv_wa] <= hv_wd;
            hn_mem[hv_wa] <= hn_wd;
        end
        hv_rd0 <= hv_mem[hv_ra0];
        hv_rd1 <= hv_mem[hv_ra1];
        hn_rd0 <= hn_mem[hv_ra0];
        hn_rd1 <= hn_mem[hv_ra1];

        if (pl_we)
        begin
            pl_mem[pl_wa] <= pl_wd;
        end
        pl_rd <= pl_mem[pl_ra];

        if (dp_we)
        begin
            dp_mem[dp_wa] <= dp_wd;
        end
        dp_rd <= dp_mem[dp_ra];

        if (us_we)
        begin
            us_mem[us_wa] <= us_wd;
        end
        us_rd <= us_mem[us_ra];
    end

    assign word_valid   = ovalid_reg;
    assign out_word     = oword_reg;
    assign valid_bytes  = ovb_reg;
    assign kind         = okind_reg;
    assign stream_bytes = osb_reg;
    assign last         = olast_reg;

    // Bit buffer never holds a full word
    a_fill_below_word: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < 6'd32)
        else $error("bit fill reached a full word");

    // Length table words always carry four bytes
    a_table_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !okind_reg) |-> (ovb_reg == 3'd4 && osb_reg == 19'd0))
        else $error("length word with partial byte count");

    // Byte count only appears on the flush word
    a_count_on_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && osb_reg != 19'd0) |-> (okind_reg && olast_reg))
        else $error("stream byte count outside flush word");

    // A partial stream word is only the flush word
    a_partial_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && okind_reg && ovb_reg != 3'd4) |-> olast_reg)
        else $error("partial stream word not marked last");

endmodule

[hw/rtl/byte_huffman_encoder_unit.sv]
// Top level of the byte Huffman encoder: command front end and execution back end.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+------------------------------------------------
//  command | cmd_valid  | cmd_stall  | cmd, sym_byte
//  word    | word_valid | word_stall | out_word, valid_bytes, kind, stream_bytes, last
//
//  Count, encode and flush each run in the back end after leaving the queue (an encode
//  past the block limit is dropped there); a 4-deep command queue lets the front accept
//  while the back is busy. Build runs a sequencer over on-chip tables: a histogram scan,
//  then per offset tried heap load, heapify, merges, depths and leaf lengths for n used
//  symbols, then canonical code assignment and sending of the 64 length words.
//  Reset is asynchronous, active low, and clears the histogram at once; no clearing pass.
//  A stalled result word holds in the output register; the back end waits to emit while it is stalled.
module byte_huffman_encoder_unit
    import bhe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  sym_byte,
    output logic        word_valid,
    input  logic        word_stall,
    output logic [31:0] out_word,
    output logic [2:0]  valid_bytes,
    output logic        kind,
    output logic [18:0] stream_bytes,
    output logic        last
);

    logic q_valid;
    op_t  q_op;
    logic q_pop;

    bhe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .sym_byte  (sym_byte),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_pop     (q_pop)
    );

    bhe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_op         (q_op),
        .q_pop        (q_pop),
        .word_valid   (word_valid),
        .word_stall   (word_stall),
        .out_word     (out_word),
        .valid_bytes  (valid_bytes),
        .kind         (kind),
        .stream_bytes (stream_bytes),
        .last         (last)
    );

endmodule
